@@ design/bnla_pkg.sv @@
// shared types, opcodes and saturation helper for the batchnorm leaky activation core
`default_nettype none
package bnla_pkg;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  localparam logic [0:0] REG_NORM_ENABLE  = 1'b0;
  localparam logic [0:0] REG_LEAKY_ENABLE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [9:0]         channel;
    logic signed [31:0] accum;
    logic signed [31:0] bin_scale_in;
    logic signed [31:0] mean_in;
    logic signed [31:0] inv_std_in;
    logic signed [31:0] gamma_in;
    logic signed [31:0] beta_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] activation_out;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] bin_scale;
    logic signed [31:0] mean;
    logic signed [31:0] inv_std;
    logic signed [31:0] gamma;
    logic signed [31:0] beta;
  } params_t;

  typedef struct packed {
    logic norm_enable;
    logic leaky_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  // clip a wide signed value to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r.val  = 32'sh7FFF_FFFF;
      r.clip = 1'b1;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r.val  = 32'sh8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = x[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/bnla_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module bnla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ design/bnla_cfg.sv @@
// apb-style configuration registers: normalization and leaky enables
`default_nettype none
module bnla_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output bnla_pkg::cfg_t   cfg
);

  logic norm_r, norm_nxt;
  logic leaky_r, leaky_nxt;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    norm_nxt  = norm_r;
    leaky_nxt = leaky_r;
    if (wr) begin
      unique case (paddr[2:2])
        bnla_pkg::REG_NORM_ENABLE:  norm_nxt  = pwdata[0];
        bnla_pkg::REG_LEAKY_ENABLE: leaky_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r  <= 1'b0;
      leaky_r <= 1'b0;
    end else begin
      norm_r  <= norm_nxt;
      leaky_r <= leaky_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      bnla_pkg::REG_NORM_ENABLE:  prdata = {31'd0, norm_r};
      bnla_pkg::REG_LEAKY_ENABLE: prdata = {31'd0, leaky_r};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg.norm_enable  = norm_r;
  assign cfg.leaky_enable = leaky_r;

endmodule
`default_nettype wire

@@ design/bnla_pipe.sv @@
// arithmetic pipeline: scale, normalize, bias, leaky relu, with per-stage valids
`default_nettype none
module bnla_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bnla_pkg::cfg_t     cfg,
  input  wire logic               issue,
  input  wire logic signed [31:0] issue_accum,
  input  wire logic               issue_in_range,
  input  wire bnla_pkg::params_t  rd_params,
  output logic                    advance,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bnla_pkg::out_item_t     out_data
);

  localparam int NSTAGE = 10;
  localparam logic signed [31:0] LEAKY_Q = 32'(((1 << FRAC_BITS) + 5) / 10);

  logic [NSTAGE:1] vld_r;
  logic [NSTAGE:1] en;

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTAGE] = !vld_r[NSTAGE] || !out_stall;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign advance = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= issue;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // s1: accumulator waits for the table read
  logic signed [31:0] acc1_r;
  logic               rng1_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      acc1_r <= issue_accum;
      rng1_r <= issue_in_range;
    end
  end

  // s2: accum times binary scale; out-of-range channels see zero parameters
  bnla_pkg::params_t  prm1;
  logic signed [63:0] p2_r;
  logic signed [31:0] mean2_r, istd2_r, gam2_r, beta2_r;
  assign prm1 = rng1_r ? rd_params : '0;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2_r    <= acc1_r * prm1.bin_scale;
      mean2_r <= prm1.mean;
      istd2_r <= prm1.inv_std;
      gam2_r  <= prm1.gamma;
      beta2_r <= prm1.beta;
    end
  end

  // s3: saturate product, subtract mean
  bnla_pkg::sat_t     v3, d3;
  logic signed [31:0] x3_r, istd3_r, gam3_r, beta3_r;
  logic               flg3_r;
  assign v3 = bnla_pkg::sat32(p2_r);
  assign d3 = bnla_pkg::sat32(64'(v3.val) - 64'(mean2_r));
  always_ff @(posedge clk) begin
    if (en[3]) begin
      x3_r    <= cfg.norm_enable ? d3.val : v3.val;
      flg3_r  <= v3.clip || (cfg.norm_enable && d3.clip);
      istd3_r <= istd2_r;
      gam3_r  <= gam2_r;
      beta3_r <= beta2_r;
    end
  end

  // s4: times inverse std
  logic signed [63:0] m4_r;
  logic signed [31:0] x4_r, gam4_r, beta4_r;
  logic               flg4_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      m4_r    <= x3_r * istd3_r;
      x4_r    <= x3_r;
      gam4_r  <= gam3_r;
      beta4_r <= beta3_r;
      flg4_r  <= flg3_r;
    end
  end

  // s5: rescale and saturate
  bnla_pkg::sat_t     n5;
  logic signed [31:0] n5_r, x5_r, gam5_r, beta5_r;
  logic               flg5_r, clip5_r;
  assign n5 = bnla_pkg::sat32(m4_r >>> FRAC_BITS);
  always_ff @(posedge clk) begin
    if (en[5]) begin
      n5_r    <= n5.val;
      clip5_r <= n5.clip;
      x5_r    <= x4_r;
      gam5_r  <= gam4_r;
      beta5_r <= beta4_r;
      flg5_r  <= flg4_r;
    end
  end

  // s6: times gamma
  logic signed [63:0] m6_r;
  logic signed [31:0] x6_r, beta6_r;
  logic               flg6_r, clip6_r;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      m6_r    <= n5_r * gam5_r;
      x6_r    <= x5_r;
      beta6_r <= beta5_r;
      flg6_r  <= flg5_r;
      clip6_r <= clip5_r;
    end
  end

  // s7: rescale, or pass the scaled value when normalization is off
  bnla_pkg::sat_t     n7;
  logic signed [31:0] n7_r, beta7_r;
  logic               flg7_r;
  assign n7 = bnla_pkg::sat32(m6_r >>> FRAC_BITS);
  always_ff @(posedge clk) begin
    if (en[7]) begin
      n7_r    <= cfg.norm_enable ? n7.val : x6_r;
      flg7_r  <= flg6_r || (cfg.norm_enable && (clip6_r || n7.clip));
      beta7_r <= beta6_r;
    end
  end

  // s8: add beta
  bnla_pkg::sat_t     b8;
  logic signed [31:0] b8_r;
  logic               flg8_r;
  assign b8 = bnla_pkg::sat32(64'(n7_r) + 64'(beta7_r));
  always_ff @(posedge clk) begin
    if (en[8]) begin
      b8_r   <= b8.val;
      flg8_r <= flg7_r || b8.clip;
    end
  end

  // s9: leaky slope product
  logic signed [63:0] m9_r;
  logic signed [31:0] b9_r;
  logic               flg9_r;
  always_ff @(posedge clk) begin
    if (en[9]) begin
      m9_r   <= b8_r * LEAKY_Q;
      b9_r   <= b8_r;
      flg9_r <= flg8_r;
    end
  end

  // s10: leaky select into the output register
  logic signed [63:0] leak9;
  logic signed [31:0] act10_r;
  logic               flg10_r;
  assign leak9 = m9_r >>> FRAC_BITS;
  always_ff @(posedge clk) begin
    if (en[10]) begin
      act10_r <= (cfg.leaky_enable && b9_r[31]) ? leak9[31:0] : b9_r;
      flg10_r <= flg9_r;
    end
  end

  assign out_valid               = vld_r[NSTAGE];
  assign out_data.activation_out = act10_r;
  assign out_data.saturated      = flg10_r;

endmodule
`default_nettype wire

@@ design/batchnorm_leaky_activation_core.sv @@
// top level of the batch normalization and leaky relu activation core
// usage:
//   input channel (in_valid / in_stall / in_data) carries one item per cycle
//   while in_stall is low. a load item (opcode 0) writes the five parameters
//   of one channel into the parameter ram at its accept edge and gives no
//   result; a load to a channel at or beyond CHANNELS is dropped.
//   a process item (opcode 1) reads its channel's parameters and runs
//   through a ten-stage pipeline: scale multiply, mean subtract, two
//   normalization multiplies, bias add, leaky slope multiply, output register.
//   its result appears on out_valid / out_data. throughput is one item per
//   cycle while out_stall is low; no stage holds more than one multiplier,
//   and the single ram read port serves one item a cycle.
//   a stalled output freezes only the stages that are full, so bubbles close
//   up and in_stall rises only once every stage holds an item.
//   configuration (norm_enable at byte 0, leaky_enable at byte 4) goes
//   through the apb-style cfg_ port and should change only while idle.
//   reset clears the pipeline valids and both enables; parameter entries stay
//   undefined until loaded.
`default_nettype none
module batchnorm_leaky_activation_core #(
  parameter int CHANNELS  = 1024,
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bnla_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bnla_pkg::out_item_t    out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  // ram address width and a zero-extended channel wide enough to compare
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = AW + 10;

  bnla_pkg::cfg_t    cfg;
  bnla_pkg::params_t wr_params;
  bnla_pkg::params_t rd_params;
  logic [EW-1:0]     chan_ext;
  logic [AW-1:0]     addr;
  logic              in_range;
  logic              advance;
  logic              accept;
  logic              load_we;
  logic              issue;

  bnla_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // channel decode: entries past the table are ignored on load, zero on read
  assign chan_ext = EW'(in_data.channel);
  assign addr     = chan_ext[AW-1:0];
  assign in_range = chan_ext < EW'(CHANNELS);

  // item accepted when valid and the first stage can take it
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign load_we  = accept && (in_data.opcode == bnla_pkg::OP_LOAD) && in_range;
  assign issue    = in_valid && (in_data.opcode == bnla_pkg::OP_PROCESS);

  assign wr_params.bin_scale = in_data.bin_scale_in;
  assign wr_params.mean      = in_data.mean_in;
  assign wr_params.inv_std   = in_data.inv_std_in;
  assign wr_params.gamma     = in_data.gamma_in;
  assign wr_params.beta      = in_data.beta_in;

  // one row per channel holds all five parameters; read on every advance so
  // the data lines up with the item entering stage one
  bnla_ram #(
    .WIDTH ($bits(bnla_pkg::params_t)),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (addr),
    .wdata (wr_params),
    .re    (advance),
    .raddr (addr),
    .rdata (rd_params)
  );

  bnla_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .issue          (issue),
    .issue_accum    (in_data.accum),
    .issue_in_range (in_range),
    .rd_params      (rd_params),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule
`default_nettype wire

@@ test/batchnorm_leaky_activation_core_tb.sv @@
// testbench for the batchnorm leaky activation core with a scoreboard and random traffic
`default_nettype none
module batchnorm_leaky_activation_core_tb;

  localparam int FRAC       = 16;
  localparam int LAT_CYCLES = 12;   // pipeline depth plus margin
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_CYCLES = 60;  // long receiver hold-off, longer than the pipeline
  localparam longint LEAKY_SLOPE = ((64'sd1 <<< FRAC) + 5) / 10;  // 0.1 in q16.16
  localparam longint Q_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_LO = -64'sh0000_0000_8000_0000;

  // byte addresses of the two registers
  localparam logic [2:0] ADDR_NORM  = {bnla_pkg::REG_NORM_ENABLE, 2'b00};
  localparam logic [2:0] ADDR_LEAKY = {bnla_pkg::REG_LEAKY_ENABLE, 2'b00};

  // handy q16.16 constants
  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MINV = 32'sh8000_0000;

  // ---------------------------------------------------------------------------
  // scoreboard: mirrors the channel tables and enables, predicts each
  // process item's activation and checks results in order
  // ---------------------------------------------------------------------------
  class activation_scoreboard;
    bnla_pkg::params_t   chan_params[1024];
    bit                  norm_on;
    bit                  leaky_on;
    bit                  clipped;
    bnla_pkg::out_item_t pending_results[$];
    int                  errors;

    function longint clip32(longint x);
      if (x > Q_HI) begin
        clipped = 1'b1;
        return Q_HI;
      end
      if (x < Q_LO) begin
        clipped = 1'b1;
        return Q_LO;
      end
      return x;
    endfunction

    function bnla_pkg::out_item_t predict_activation(logic [9:0] ch,
                                                     logic signed [31:0] acc);
      bnla_pkg::params_t   p;
      longint              v, n, b, r;
      bnla_pkg::out_item_t res;
      p = chan_params[ch];
      clipped = 1'b0;
      v = clip32(longint'(acc) * longint'(p.bin_scale));
      if (norm_on) begin
        n = clip32(v - longint'(p.mean));
        n = clip32((n * longint'(p.inv_std)) >>> FRAC);
        n = clip32((n * longint'(p.gamma)) >>> FRAC);
      end else begin
        n = v;
      end
      b = clip32(n + longint'(p.beta));
      r = (leaky_on && b < 0) ? ((b * LEAKY_SLOPE) >>> FRAC) : b;
      res.activation_out = r[31:0];
      res.saturated      = clipped;
      return res;
    endfunction

    // called at the edge an item is accepted
    function void note_item(bnla_pkg::in_item_t it);
      if (it.opcode == bnla_pkg::OP_LOAD) begin
        chan_params[it.channel] = '{bin_scale: it.bin_scale_in, mean: it.mean_in,
                                    inv_std: it.inv_std_in, gamma: it.gamma_in,
                                    beta: it.beta_in};
      end else begin
        pending_results.push_back(predict_activation(it.channel, it.accum));
      end
    endfunction

    function void check_result(bnla_pkg::out_item_t got);
      bnla_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item pending: activation_out %0d saturated %0d",
               got.activation_out, got.saturated);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.activation_out !== want.activation_out) begin
        $error("activation_out mismatch: expected %0d actual %0d",
               want.activation_out, got.activation_out);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated mismatch: expected %0d actual %0d", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals
  // ---------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bnla_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bnla_pkg::out_item_t out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [2:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  activation_scoreboard sb;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;      // bumped by the stimulus to ask for a long receiver hold-off
  int hold_seen;
  int hold_left;

  bit loaded_map[1024];
  int loaded_chans[$];

  batchnorm_leaky_activation_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // result side: check accepted results, then decide the next stall.
  // values read here are the ones from before the edge, so the accept
  // decision matches what the core saw
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
    if (hold_left == 0 && hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      // hold off long enough for the whole pipeline to fill and stall the input
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item after a random gap and hold it until accepted
  task automatic send_item(input bnla_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    if (it.opcode == bnla_pkg::OP_LOAD && !loaded_map[it.channel]) begin
      loaded_map[it.channel] = 1'b1;
      loaded_chans.push_back(it.channel);
    end
  endtask

  // stop offering and wait for every pending result, then the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  // register write: setup phase, then access phase until pready
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_modes(input bit norm, input bit leaky);
    write_reg(ADDR_NORM, {31'd0, norm});
    sb.norm_on = norm;
    write_reg(ADDR_LEAKY, {31'd0, leaky});
    sb.leaky_on = leaky;
  endtask

  // signed value: mostly within +-2^(span-1), sometimes extremes or full range
  function automatic logic signed [31:0] pick_value(input int span);
    case ($urandom_range(9))
      0:       return Q_MAXV;
      1:       return Q_MINV;
      2:       return 32'sd0;
      3, 4:    return $urandom;
      default: return int'($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
    endcase
  endfunction

  function automatic bnla_pkg::in_item_t load_item(input logic [9:0] ch,
                                                   input logic signed [31:0] sc,
                                                   input logic signed [31:0] mn,
                                                   input logic signed [31:0] isd,
                                                   input logic signed [31:0] gm,
                                                   input logic signed [31:0] bt);
    bnla_pkg::in_item_t it;
    it.opcode       = bnla_pkg::OP_LOAD;
    it.channel      = ch;
    it.accum        = $urandom;   // ignored on a load
    it.bin_scale_in = sc;
    it.mean_in      = mn;
    it.inv_std_in   = isd;
    it.gamma_in     = gm;
    it.beta_in      = bt;
    return it;
  endfunction

  function automatic bnla_pkg::in_item_t process_item(input logic [9:0] ch,
                                                      input logic signed [31:0] acc);
    bnla_pkg::in_item_t it;
    it.opcode       = bnla_pkg::OP_PROCESS;
    it.channel      = ch;
    it.accum        = acc;
    // parameter fields carry junk, the core must ignore them
    it.bin_scale_in = $urandom;
    it.mean_in      = $urandom;
    it.inv_std_in   = $urandom;
    it.gamma_in     = $urandom;
    it.beta_in      = $urandom;
    return it;
  endfunction

  // mostly processing on loaded channels, with table reloads mixed in
  function automatic bnla_pkg::in_item_t random_item();
    logic [9:0] ch;
    if ($urandom_range(99) < 20) begin
      ch = ($urandom_range(9) < 7) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
      return load_item(ch, pick_value(18), pick_value(20), pick_value(18),
                       pick_value(18), pick_value(20));
    end
    ch = 10'(loaded_chans[$urandom_range(loaded_chans.size() - 1)]);
    return process_item(ch, pick_value(13));
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, both enables at their reset value first
    set_modes(1'b0, 1'b0);
    // table extremes: all-max at the lowest channel, all-min at the highest
    send_item(load_item(10'd0, Q_MAXV, Q_MAXV, Q_MAXV, Q_MAXV, Q_MAXV));
    send_item(load_item(10'd1023, Q_MINV, Q_MINV, Q_MINV, Q_MINV, Q_MINV));
    // unity parameters
    send_item(load_item(10'd5, Q_ONE, 32'sd0, Q_ONE, Q_ONE, 32'sd0));
    // typical mix: scale -1.5, mean 0.5, inv std 2.0, gamma 0.75, beta -3.0
    send_item(load_item(10'd6, 32'shFFFE_8000, 32'sh0000_8000, 32'sh0002_0000,
                        32'sh0000_C000, 32'shFFFD_0000));
    send_item(process_item(10'd0, Q_MAXV));
    send_item(process_item(10'd0, Q_MINV));
    send_item(process_item(10'd0, 32'sd0));
    send_item(process_item(10'd0, 32'sd1));
    send_item(process_item(10'd1023, Q_MAXV));
    send_item(process_item(10'd1023, Q_MINV));
    send_item(process_item(10'd1023, -32'sd1));
    send_item(process_item(10'd5, 32'sd0));
    send_item(process_item(10'd5, 32'sd3));
    send_item(process_item(10'd5, -32'sd3));
    // around the edge of the scale product: fits, one over, exact minimum, one under
    send_item(process_item(10'd5, 32'sh0000_7FFF));
    send_item(process_item(10'd5, 32'sh0000_8000));
    send_item(process_item(10'd5, -32'sh0000_8000));
    send_item(process_item(10'd5, -32'sh0000_8001));
    send_item(process_item(10'd6, -32'sd7));
    send_item(process_item(10'd6, 32'sd100));
    drain();

    // random phases: every enable setting under each idling pattern
    for (int p = 0; p < 12; p++) begin
      set_modes(p[0], p[1]);
      case (p / 4)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver holds off while the sender keeps offering, filling the pipe
        if (p == 8 && i == 10) hold_req = hold_req + 1;
        // sender pauses until everything in flight has come out
        if (p == 5 && i == 25) begin
          in_valid <= 1'b0;
          while (sb.pending_results.size() != 0) @(posedge clk);
        end
        send_item(random_item());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #800000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
design/bnla_pkg.sv
design/bnla_ram.sv
design/bnla_cfg.sv
design/bnla_pipe.sv
design/batchnorm_leaky_activation_core.sv
test/batchnorm_leaky_activation_core_tb.sv
